// ----- hw/rtl/dosv_pkg.sv -----
// Shared types, constants and register map of the draw-op stream validator.
package dosv_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Limits on operand values
  localparam logic [WordW-1:0] Lim20    = 32'h0010_0000;
  localparam logic [WordW-1:0] Lim24    = 32'h0100_0000;
  localparam logic [WordW-1:0] NegLim20 = 32'hFFF0_0000;
  localparam logic [WordW-1:0] CpMax    = 32'h0010_FFFF;

  // Fixed operand counts, and the minimum count for text
  localparam logic [LenW-1:0] RectLen  = 24'd5;
  localparam logic [LenW-1:0] ImageLen = 24'd5;
  localparam logic [LenW-1:0] FieldLen = 24'd6;
  localparam logic [LenW-1:0] TextMin  = 24'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgRectCode     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTextCode     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImageCode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFieldCode    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTextCharsMax = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgImageCount   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFieldCount   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgFieldKindMax = 3'd7;

  typedef enum logic [1:0] {
    OpRect  = 2'd0,
    OpText  = 2'd1,
    OpImage = 2'd2,
    OpField = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [7:0]  rect_code;
    logic [7:0]  text_code;
    logic [7:0]  image_code;
    logic [7:0]  field_code;
    logic [15:0] text_chars_max;
    logic [15:0] image_count;
    logic [15:0] field_count;
    logic [7:0]  field_kind_max;
  } cfg_t;

  // Outcome of checking one op word against the current op state
  typedef struct packed {
    logic            pass;
    op_kind_e        kind;
    logic [LenW-1:0] len;
  } chk_t;

endpackage

// ----- hw/rtl/dosv_check.sv -----
// Head-word and operand range checks for one op word.
module dosv_check (
  input  logic [dosv_pkg::WordW-1:0] word_i,
  input  logic                       in_op_i,
  input  dosv_pkg::op_kind_e         kind_now_i,
  input  logic [dosv_pkg::LenW-1:0]  idx_i,
  input  dosv_pkg::cfg_t             cfg_i,
  output dosv_pkg::chk_t             res_o
);

  logic [7:0]                k_code;
  logic [dosv_pkg::LenW-1:0] n_cnt;
  logic [dosv_pkg::LenW-1:0] n_extra;
  logic                      head_pass;
  dosv_pkg::op_kind_e        head_kind;
  logic                      neg;
  logic                      ge_m20;
  logic                      le_20;
  logic                      le_24;
  logic                      u_le_20;
  logic                      idx_is_sz;
  logic                      opnd_pass;

  assign k_code  = word_i[31:24];
  assign n_cnt   = word_i[23:0];
  assign n_extra = n_cnt - dosv_pkg::TextMin;

  // First matching code in rect, text, image, field order wins
  always_comb begin
    head_kind = dosv_pkg::OpRect;
    head_pass = 1'b0;
    if (k_code == cfg_i.rect_code) begin
      head_kind = dosv_pkg::OpRect;
      head_pass = (n_cnt == dosv_pkg::RectLen);
    end else if (k_code == cfg_i.text_code) begin
      head_kind = dosv_pkg::OpText;
      head_pass = (n_cnt >= dosv_pkg::TextMin) &&
                  (n_extra <= {8'd0, cfg_i.text_chars_max});
    end else if (k_code == cfg_i.image_code) begin
      head_kind = dosv_pkg::OpImage;
      head_pass = (n_cnt == dosv_pkg::ImageLen);
    end else if (k_code == cfg_i.field_code) begin
      head_kind = dosv_pkg::OpField;
      head_pass = (n_cnt == dosv_pkg::FieldLen);
    end
  end

  assign neg       = word_i[31];
  assign ge_m20    = !neg || (word_i >= dosv_pkg::NegLim20);
  assign le_20     = neg || (word_i <= dosv_pkg::Lim20);
  assign le_24     = neg || (word_i <= dosv_pkg::Lim24);
  assign u_le_20   = (word_i <= dosv_pkg::Lim20);
  assign idx_is_sz = (idx_i == 24'd2) || (idx_i == 24'd3);

  always_comb begin
    opnd_pass = 1'b1;
    if (idx_i == 24'd0) begin
      opnd_pass = ge_m20 && le_20;
    end else if (idx_i == 24'd1) begin
      opnd_pass = ge_m20 && le_24;
    end else begin
      case (kind_now_i)
        dosv_pkg::OpRect: begin
          if (idx_is_sz) opnd_pass = u_le_20;
        end
        dosv_pkg::OpText: begin
          if (idx_i == 24'd2) begin
            opnd_pass = (word_i[31:24] >= 8'd1) && (word_i[31:24] <= 8'd3);
          end else begin
            opnd_pass = (word_i <= dosv_pkg::CpMax);
          end
        end
        dosv_pkg::OpImage: begin
          if (idx_is_sz) opnd_pass = (word_i != '0) && u_le_20;
          else if (idx_i == 24'd4) opnd_pass = (word_i < {16'd0, cfg_i.image_count});
        end
        default: begin
          if (idx_is_sz) opnd_pass = (word_i != '0) && u_le_20;
          else if (idx_i == 24'd4) opnd_pass = (word_i < {16'd0, cfg_i.field_count});
          else if (idx_i == 24'd5) opnd_pass = (word_i <= {24'd0, cfg_i.field_kind_max});
        end
      endcase
    end
  end

  assign res_o.pass = in_op_i ? opnd_pass : head_pass;
  assign res_o.kind = head_kind;
  assign res_o.len  = n_cnt;

endmodule

// ----- hw/rtl/draw_op_stream_validator.sv -----
// Top level of the draw-op stream validator: input register, op state, verdict register.
// An end marker's verdict passes the input register, then the verdict register, to the master side.
// Throughput: one item per cycle; only an end marker waits, while the verdict register is full and not taken.
// The rate is set by the single verdict register; an op word in the input register always advances.
// Reset: op state and stream flags clear, registers take their documented defaults.
module draw_op_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] word
  input  logic [0:0]  s_axis_tuser,   // [0] kind (1 = end of op area)
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] ok, [7:1] zero
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dosv_pkg::cfg_t cfg_q;

  logic        s1_valid_q;
  logic        s1_end_q;
  logic [31:0] s1_word_q;

  logic                      failed_q;
  dosv_pkg::op_kind_e        kind_now_q;
  logic [dosv_pkg::LenW-1:0] op_length_q;
  logic [dosv_pkg::LenW-1:0] idx_q;
  logic                      in_op_q;

  logic out_valid_q;
  logic ok_q;

  logic                      out_free;
  logic                      adv;
  logic [dosv_pkg::LenW-1:0] idx_inc;
  dosv_pkg::chk_t            chk;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_code      <= 8'd0;
      cfg_q.text_code      <= 8'd1;
      cfg_q.image_code     <= 8'd2;
      cfg_q.field_code     <= 8'd3;
      cfg_q.text_chars_max <= 16'd256;
      cfg_q.image_count    <= 16'd0;
      cfg_q.field_count    <= 16'd0;
      cfg_q.field_kind_max <= 8'd7;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dosv_pkg::CfgRectCode:     cfg_q.rect_code      <= cfg_data_i[7:0];
        dosv_pkg::CfgTextCode:     cfg_q.text_code      <= cfg_data_i[7:0];
        dosv_pkg::CfgImageCode:    cfg_q.image_code     <= cfg_data_i[7:0];
        dosv_pkg::CfgFieldCode:    cfg_q.field_code     <= cfg_data_i[7:0];
        dosv_pkg::CfgTextCharsMax: cfg_q.text_chars_max <= cfg_data_i;
        dosv_pkg::CfgImageCount:   cfg_q.image_count    <= cfg_data_i;
        dosv_pkg::CfgFieldCount:   cfg_q.field_count    <= cfg_data_i;
        dosv_pkg::CfgFieldKindMax: cfg_q.field_kind_max <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // An end marker needs the verdict register; op words always advance
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = s1_valid_q && (!s1_end_q || out_free);
  assign s_axis_tready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_end_q   <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
      s1_end_q   <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) s1_word_q <= s_axis_tdata;
  end

  dosv_check u_check (
    .word_i    (s1_word_q),
    .in_op_i   (in_op_q),
    .kind_now_i(kind_now_q),
    .idx_i     (idx_q),
    .cfg_i     (cfg_q),
    .res_o     (chk)
  );

  assign idx_inc = idx_q + 24'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q    <= 1'b0;
      kind_now_q  <= dosv_pkg::OpRect;
      op_length_q <= '0;
      idx_q       <= '0;
      in_op_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (m_axis_tready) out_valid_q <= 1'b0;
      if (adv) begin
        if (s1_end_q) begin
          // Give the verdict and clear the stream state
          out_valid_q <= 1'b1;
          ok_q        <= !failed_q && !in_op_q;
          failed_q    <= 1'b0;
          kind_now_q  <= dosv_pkg::OpRect;
          op_length_q <= '0;
          idx_q       <= '0;
          in_op_q     <= 1'b0;
        end else if (!failed_q) begin
          if (!in_op_q) begin
            kind_now_q <= chk.kind;
            if (chk.pass) begin
              op_length_q <= chk.len;
              idx_q       <= '0;
              in_op_q     <= 1'b1;
            end else begin
              failed_q <= 1'b1;
            end
          end else if (!chk.pass) begin
            failed_q <= 1'b1;
            in_op_q  <= 1'b0;
          end else if (idx_inc >= op_length_q) begin
            idx_q   <= '0;
            in_op_q <= 1'b0;
          end else begin
            idx_q <= idx_inc;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, ok_q};

`ifndef ASSERT_OFF
  a_op_not_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_op_q |-> !failed_q)
    else $error("op in progress after a failure");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_op_q |-> (idx_q < op_length_q))
    else $error("operand index past op length");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_end_q) |=> (!in_op_q && !failed_q && m_axis_tvalid))
    else $error("end marker did not clear state or give a verdict");

  a_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_end_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("item taken while an end marker waits");
`endif

endmodule

// ----- sim/tb.sv -----
// Testbench of the draw-op stream validator: directed and random op areas checked against a verdict predictor.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic                       end_mark;
    logic [dosv_pkg::WordW-1:0] word;
  } stream_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] word
  logic [0:0]  s_axis_tuser = '0;  // [0] kind (1 = end of op area)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [0] ok, [7:1] zero
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // register copy and op state of the verdict predictor
  dosv_pkg::cfg_t            regs;
  logic                      area_failed = 1'b0;
  logic                      op_open = 1'b0;
  dosv_pkg::op_kind_e        op_kind = dosv_pkg::OpRect;
  logic [dosv_pkg::LenW-1:0] op_len = '0;
  logic [dosv_pkg::LenW-1:0] operand_pos = '0;

  stream_item_t words_to_send[$];
  logic         verdicts_due[$];
  int unsigned  mismatches = 0;
  int unsigned  send_gap_pct = 18;
  int unsigned  recv_stall_pct = 52;

  draw_op_stream_validator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic head_accepts(input logic [dosv_pkg::WordW-1:0] w);
    logic [7:0]                code;
    logic [dosv_pkg::LenW-1:0] n;
    logic                      legal;
    code = w[31:24];
    n = w[dosv_pkg::LenW-1:0];
    // first matching code wins when codes overlap
    if (code == regs.rect_code) begin
      op_kind = dosv_pkg::OpRect;
      legal = (n == dosv_pkg::RectLen);
    end else if (code == regs.text_code) begin
      op_kind = dosv_pkg::OpText;
      legal = (n >= dosv_pkg::TextMin) &&
              (n - dosv_pkg::TextMin <= {8'd0, regs.text_chars_max});
    end else if (code == regs.image_code) begin
      op_kind = dosv_pkg::OpImage;
      legal = (n == dosv_pkg::ImageLen);
    end else if (code == regs.field_code) begin
      op_kind = dosv_pkg::OpField;
      legal = (n == dosv_pkg::FieldLen);
    end else begin
      legal = 1'b0;
    end
    if (legal) begin
      op_len = n;
      operand_pos = '0;
      op_open = 1'b1;
    end
    return legal;
  endfunction

  function automatic logic operand_fits(input logic [dosv_pkg::LenW-1:0] pos,
                                        input logic [dosv_pkg::WordW-1:0] w);
    logic signed [dosv_pkg::WordW-1:0] s;
    s = w;
    if (pos == 0) begin
      return (s >= $signed(dosv_pkg::NegLim20)) && (s <= $signed(dosv_pkg::Lim20));
    end
    if (pos == 1) begin
      return (s >= $signed(dosv_pkg::NegLim20)) && (s <= $signed(dosv_pkg::Lim24));
    end
    case (op_kind)
      dosv_pkg::OpRect: begin
        if (pos == 2 || pos == 3) return (s >= 0) && (w <= dosv_pkg::Lim20);
      end
      dosv_pkg::OpText: begin
        if (pos == 2) return (w[31:24] >= 8'd1) && (w[31:24] <= 8'd3);
        return w <= dosv_pkg::CpMax;
      end
      dosv_pkg::OpImage: begin
        if (pos == 2 || pos == 3) return (s > 0) && (w <= dosv_pkg::Lim20);
        if (pos == 4) return w < {16'd0, regs.image_count};
      end
      default: begin
        if (pos == 2 || pos == 3) return (s > 0) && (w <= dosv_pkg::Lim20);
        if (pos == 4) return w < {16'd0, regs.field_count};
        if (pos == 5) return w <= {24'd0, regs.field_kind_max};
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void follow_word(input logic [dosv_pkg::WordW-1:0] w);
    // words after a failure are dropped until the end marker
    if (area_failed) return;
    if (!op_open) begin
      if (!head_accepts(w)) area_failed = 1'b1;
      return;
    end
    if (!operand_fits(operand_pos, w)) begin
      area_failed = 1'b1;
      op_open = 1'b0;
      return;
    end
    operand_pos = operand_pos + 1'b1;
    if (operand_pos >= op_len) begin
      op_open = 1'b0;
      operand_pos = '0;
    end
  endfunction

  function automatic logic close_area();
    logic ok;
    ok = !area_failed && !op_open;
    area_failed = 1'b0;
    op_open = 1'b0;
    op_kind = dosv_pkg::OpRect;
    op_len = '0;
    operand_pos = '0;
    return ok;
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk_i) begin : drive
    stream_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = words_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.end_mark;
        s_axis_tdata <= nxt.word;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : watch
    logic want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("ok: expected none, actual %0b", m_axis_tdata[0]);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $error("ok: expected %0b, actual %0b", want, m_axis_tdata[0]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) verdicts_due.push_back(close_area());
        else follow_word(s_axis_tdata);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input logic [dosv_pkg::WordW-1:0] w);
    words_to_send.push_back({1'b0, w});
  endtask

  task automatic push_end();
    words_to_send.push_back({1'b1, 32'($urandom())});
  endtask

  // hold until every item is taken and every verdict is back, then let the pipe drain
  task automatic settle();
    while (words_to_send.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dosv_pkg::CfgIdxW-1:0] idx,
                           input logic [dosv_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      dosv_pkg::CfgRectCode:     regs.rect_code = val[7:0];
      dosv_pkg::CfgTextCode:     regs.text_code = val[7:0];
      dosv_pkg::CfgImageCode:    regs.image_code = val[7:0];
      dosv_pkg::CfgFieldCode:    regs.field_code = val[7:0];
      dosv_pkg::CfgTextCharsMax: regs.text_chars_max = val;
      dosv_pkg::CfgImageCount:   regs.image_count = val;
      dosv_pkg::CfgFieldCount:   regs.field_count = val;
      default:                   regs.field_kind_max = val[7:0];
    endcase
  endtask

  // upper byte of the 8-bit registers is noise and must be dropped
  task automatic set_all(input logic [7:0] rc, input logic [7:0] tc, input logic [7:0] ic,
                         input logic [7:0] fc, input logic [15:0] tmax,
                         input logic [15:0] icnt, input logic [15:0] fcnt,
                         input logic [7:0] fkmax);
    write_reg(dosv_pkg::CfgRectCode, {8'($urandom()), rc});
    write_reg(dosv_pkg::CfgTextCode, {8'($urandom()), tc});
    write_reg(dosv_pkg::CfgImageCode, {8'($urandom()), ic});
    write_reg(dosv_pkg::CfgFieldCode, {8'($urandom()), fc});
    write_reg(dosv_pkg::CfgTextCharsMax, tmax);
    write_reg(dosv_pkg::CfgImageCount, icnt);
    write_reg(dosv_pkg::CfgFieldCount, fcnt);
    write_reg(dosv_pkg::CfgFieldKindMax, {8'($urandom()), fkmax});
  endtask

  function automatic logic [7:0] code_of(input dosv_pkg::op_kind_e k);
    case (k)
      dosv_pkg::OpRect:  return regs.rect_code;
      dosv_pkg::OpText:  return regs.text_code;
      dosv_pkg::OpImage: return regs.image_code;
      default:           return regs.field_code;
    endcase
  endfunction

  function automatic logic [dosv_pkg::WordW-1:0] below_pick(input logic [15:0] count,
                                                            input logic wrong);
    if (wrong || count == 0) return {16'd0, count} + $urandom_range(2);
    return $urandom_range(1) ? {16'd0, count} - 1 : $urandom_range(count - 1);
  endfunction

  function automatic logic [dosv_pkg::WordW-1:0] pick_operand(input dosv_pkg::op_kind_e k,
                                                              input int pos);
    int unsigned r;
    logic        wrong;
    logic [7:0]  style;
    r = $urandom_range(99);
    wrong = (r < 8);
    if (r < 3) return $urandom();
    if (pos == 0) begin
      if (wrong) return $urandom_range(1) ? dosv_pkg::NegLim20 - 1 : dosv_pkg::Lim20 + 1;
      case ($urandom_range(2))
        0:       return dosv_pkg::NegLim20;
        1:       return dosv_pkg::Lim20;
        default: return $urandom_range(2 * dosv_pkg::Lim20) - dosv_pkg::Lim20;
      endcase
    end
    if (pos == 1) begin
      if (wrong) return $urandom_range(1) ? dosv_pkg::NegLim20 - 1 : dosv_pkg::Lim24 + 1;
      case ($urandom_range(2))
        0:       return dosv_pkg::NegLim20;
        1:       return dosv_pkg::Lim24;
        default: return $urandom_range(dosv_pkg::Lim24 + dosv_pkg::Lim20) - dosv_pkg::Lim20;
      endcase
    end
    if (k == dosv_pkg::OpText) begin
      if (pos == 2) begin
        if (!wrong) style = 8'($urandom_range(3, 1));
        else style = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 4));
        return {style, 24'($urandom())};
      end
      if (wrong) return dosv_pkg::CpMax + 1;
      return $urandom_range(1) ? dosv_pkg::CpMax : $urandom_range(dosv_pkg::CpMax);
    end
    if (pos == 2 || pos == 3) begin
      if (k == dosv_pkg::OpRect) begin
        if (wrong) return $urandom_range(1) ? dosv_pkg::Lim20 + 1 : 32'hFFFF_FFFF;
        return $urandom_range(1) ? ($urandom_range(1) ? 32'd0 : dosv_pkg::Lim20)
                                 : $urandom_range(dosv_pkg::Lim20);
      end
      if (wrong) return $urandom_range(1) ? 32'd0 : dosv_pkg::Lim20 + 1;
      return $urandom_range(1) ? dosv_pkg::Lim20 : $urandom_range(dosv_pkg::Lim20, 1);
    end
    if (pos == 4 && k == dosv_pkg::OpImage) return below_pick(regs.image_count, wrong);
    if (pos == 4 && k == dosv_pkg::OpField) return below_pick(regs.field_count, wrong);
    if (pos == 5 && k == dosv_pkg::OpField) begin
      if (wrong) return {24'd0, regs.field_kind_max} + 1;
      return $urandom_range(1) ? {24'd0, regs.field_kind_max}
                               : $urandom_range(regs.field_kind_max);
    end
    return $urandom();
  endfunction

  task automatic add_op(input dosv_pkg::op_kind_e k, input logic cut);
    int unsigned               span;
    int unsigned               sent;
    int unsigned               r;
    logic [dosv_pkg::LenW-1:0] cnt;
    if (k == dosv_pkg::OpRect || k == dosv_pkg::OpImage) span = 5;
    else if (k == dosv_pkg::OpField) span = 6;
    else span = 3 + $urandom_range(regs.text_chars_max < 6 ? regs.text_chars_max : 6);
    r = $urandom_range(99);
    if (k == dosv_pkg::OpText && r < 6 && regs.text_chars_max <= 40) begin
      span = 3 + regs.text_chars_max;
    end
    cnt = dosv_pkg::LenW'(span);
    if (r >= 94) begin
      case ($urandom_range(2))
        0:       cnt = dosv_pkg::LenW'($urandom());
        1:       cnt = (k == dosv_pkg::OpText) ?
                       dosv_pkg::LenW'(regs.text_chars_max) + dosv_pkg::TextMin + 1 : cnt + 1;
        default: cnt = (k == dosv_pkg::OpText) ? dosv_pkg::LenW'($urandom_range(2)) : cnt - 1;
      endcase
    end
    push_word({(r >= 90 && r < 94) ? 8'($urandom()) : code_of(k), cnt});
    sent = cut ? $urandom_range(span - 1) : span;
    for (int i = 0; i < sent; i++) push_word(pick_operand(k, i));
  endtask

  task automatic add_area();
    int unsigned ops;
    logic        cut;
    ops = $urandom_range(4);
    for (int i = 0; i < ops; i++) begin
      if ($urandom_range(99) < 5) push_word($urandom());
      cut = ($urandom_range(99) < 5);
      add_op(dosv_pkg::op_kind_e'($urandom_range(3)), cut);
      if (cut) break;
    end
    push_end();
  endtask

  task automatic fill_random(input int unsigned amount);
    while (words_to_send.size() < amount) add_area();
  endtask

  initial begin
    regs.rect_code = 8'd0;
    regs.text_code = 8'd1;
    regs.image_code = 8'd2;
    regs.field_code = 8'd3;
    regs.text_chars_max = 16'd256;
    regs.image_count = 16'd0;
    regs.field_count = 16'd0;
    regs.field_kind_max = 8'd7;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: empty area, extreme rect and text ops, an op cut short
    push_end();
    push_word(32'h0000_0005);
    push_word(dosv_pkg::NegLim20);
    push_word(dosv_pkg::Lim24);
    push_word(32'h0000_0000);
    push_word(dosv_pkg::Lim20);
    push_word(32'hFFFF_FFFF);
    push_end();
    push_word(32'h0100_0004);
    push_word(dosv_pkg::Lim20);
    push_word(dosv_pkg::NegLim20);
    push_word(32'h03AB_CDEF);
    push_word(dosv_pkg::CpMax);
    push_end();
    push_word(32'h0000_0005);
    push_end();
    settle();

    // rect and text share a code: rect wins, so a 3-operand head fails and the rest is dropped
    write_reg(dosv_pkg::CfgTextCode, 16'h0000);
    write_reg(dosv_pkg::CfgImageCount, 16'd3);
    write_reg(dosv_pkg::CfgFieldCount, 16'd2);
    push_word(32'h0000_0003);
    push_word(32'h0300_0006);
    push_word(32'h0000_0000);
    push_word(32'h0000_0000);
    push_word(32'h0000_0001);
    push_word(dosv_pkg::Lim20);
    push_word(32'h0000_0001);
    push_word(32'h0000_0007);
    push_end();
    push_end();
    settle();

    set_all(8'h10, 8'h20, 8'h30, 8'h40, 16'd8, 16'd4, 16'd4, 8'd3);
    fill_random(150);
    settle();
    set_all(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd0, 16'hFFFF, 16'd1, 8'hFF);
    fill_random(150);
    settle();

    send_gap_pct = 52;
    recv_stall_pct = 18;
    set_all(8'h00, 8'h80, 8'h7F, 8'hFF, 16'd1, 16'd1, 16'hFFFF, 8'd0);
    fill_random(150);
    settle();
    set_all(8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'd16, 16'd0, 16'd0, 8'd7);
    fill_random(150);
    settle();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_all(8'h01, 8'h02, 8'h03, 8'h04, 16'hFFFF, 16'd100, 16'd100, 8'd128);
    // longest legal text head cut short, then one code point too many
    push_word({regs.text_code, 24'd65538});
    push_word(32'h0000_0000);
    push_word(32'h0000_0000);
    push_word({8'd2, 24'($urandom())});
    push_end();
    push_word({regs.text_code, 24'd65539});
    push_end();
    fill_random(150);
    settle();
    set_all(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
            16'($urandom_range(20)), 16'($urandom()), 16'($urandom()), 8'($urandom()));
    fill_random(150);
    settle();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dosv_pkg.sv
hw/rtl/dosv_check.sv
hw/rtl/draw_op_stream_validator.sv
sim/tb.sv
